@@ hw/rtl/hgt_pkg.sv @@
package hgt_pkg;

   localparam int MAX_BONES = 256;
   localparam int IDX_W = (MAX_BONES > 2) ? $clog2(MAX_BONES) : 1;
   localparam int CNT_W = $clog2(MAX_BONES + 1);
   localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic signed [15:0] rot_w;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [15:0] rot_z;
      logic signed [23:0] scale_x;
      logic signed [23:0] scale_y;
      logic signed [23:0] scale_z;
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
   } xform_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_UVP,
      ST_UVR,
      ST_UUP,
      ST_FIN
   } state_type;

endpackage

@@ hw/rtl/hierarchy_global_transform_top.sv @@
// Forward kinematics over a skeleton whose bones arrive in topological order.
// The req_ channel carries one bone word: restart flag, parent index and the
// local rotation (Q2.14), scale (Q8.16) and translation (Q16.16).
// The rsp_ channel returns one word per bone: its index, a status code and the
// global transform, saturated to the same formats.
// A bone is accepted only while the sequencer is idle. Its parent transform is
// read from a synchronous memory, then the quaternion product, scale products
// and the rotated translation run through a step sequencer (LOAD, SUM, UVP,
// UVR, UUP, FIN) that ends in the result register, and the next bone is
// accepted only once the sequencer is idle again. The chain of dependent
// multiplications in the translation rotation sets the length of that sequence.
// The result register decouples the two sides: the next bone is accepted while
// a result waits, and if the receiver stalls, the following bone holds in its
// last step until the result register frees up.
// Reset clears the bone count and the control state; the transform memory is
// not cleared, since only entries written in the current skeleton are used.
module hierarchy_global_transform_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_first_bone,
   input  logic signed [8:0]  req_parent_index,
   input  logic signed [15:0] req_local_rot_w,
   input  logic signed [15:0] req_local_rot_x,
   input  logic signed [15:0] req_local_rot_y,
   input  logic signed [15:0] req_local_rot_z,
   input  logic signed [23:0] req_local_scale_x,
   input  logic signed [23:0] req_local_scale_y,
   input  logic signed [23:0] req_local_scale_z,
   input  logic signed [31:0] req_local_move_x,
   input  logic signed [31:0] req_local_move_y,
   input  logic signed [31:0] req_local_move_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_bone_number,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_world_rot_w,
   output logic signed [15:0] rsp_world_rot_x,
   output logic signed [15:0] rsp_world_rot_y,
   output logic signed [15:0] rsp_world_rot_z,
   output logic signed [23:0] rsp_world_scale_x,
   output logic signed [23:0] rsp_world_scale_y,
   output logic signed [23:0] rsp_world_scale_z,
   output logic signed [31:0] rsp_world_move_x,
   output logic signed [31:0] rsp_world_move_y,
   output logic signed [31:0] rsp_world_move_z
);
   import hgt_pkg::*;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) return 16'sh7FFF;
      else if (v < -64'sd32768) return 16'sh8000;
      else return 16'(v);
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      else if (v < -64'sd8388608) return 24'sh800000;
      else return 24'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return 32'(v);
   endfunction

   xform_type mem [MAX_BONES];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] seen_ff;
   logic [CNT_W-1:0] idx_ff;
   logic full_ff, ok_ff;
   logic [1:0] status_ff;
   xform_type loc_ff, par_ff, world;

   logic signed [31:0] qp_ff [16];
   logic signed [47:0] sp_ff [3];
   logic signed [55:0] vp_ff [3];
   logic signed [15:0] rot_ff [4];
   logic signed [23:0] scl_ff [3];
   logic signed [63:0] v_ff [3];
   logic signed [63:0] uvp_ff [6];
   logic signed [63:0] uv_ff [3];
   logic signed [63:0] uup_ff [6];
   logic signed [63:0] uvw_ff [3];

   logic rsp_valid_ff;
   logic [7:0] bone_ff;
   logic [1:0] st_out_ff;
   xform_type out_ff;

   logic accept, fin_go, out_free;

   logic [CNT_W-1:0] idx_new;
   logic [CMP_W-1:0] par_cmp, idx_cmp;
   logic par_ok, par_root;

   logic signed [15:0] pq [4];
   logic signed [15:0] cq [4];
   logic signed [63:0] mv [3];

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_SUM;
         ST_SUM:  state_in = ST_UVP;
         ST_UVP:  state_in = ST_UVR;
         ST_UVR:  state_in = ST_UUP;
         ST_UUP:  state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_ready && req_valid;
      fin_go    = (state_ff == ST_FIN) && out_free;
   end

   always_comb begin
      idx_new  = req_first_bone ? '0 : seen_ff;
      par_cmp  = CMP_W'(req_parent_index[7:0]);
      idx_cmp  = CMP_W'(idx_new);
      par_root = (req_parent_index == -9'sd1);
      par_ok   = !req_parent_index[8] && (par_cmp < idx_cmp)
                 && (par_cmp < CMP_W'(MAX_BONES));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && req_first_bone) seen_ff <= '0;
         if (fin_go && !full_ff) seen_ff <= idx_ff + CNT_W'(1);
         if (fin_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         par_ff  <= mem[IDX_W'(req_parent_index[7:0])];
         idx_ff  <= idx_new;
         full_ff <= (idx_new >= CNT_W'(MAX_BONES));
         ok_ff   <= par_ok;
         if (idx_new >= CNT_W'(MAX_BONES)) status_ff <= STATUS_FULL;
         else if (par_ok || par_root) status_ff <= STATUS_OK;
         else status_ff <= STATUS_BAD;
         loc_ff <= '{req_local_rot_w, req_local_rot_x, req_local_rot_y, req_local_rot_z,
                     req_local_scale_x, req_local_scale_y, req_local_scale_z,
                     req_local_move_x, req_local_move_y, req_local_move_z};
      end
      if (fin_go && !full_ff) begin
         mem[IDX_W'(idx_ff)] <= world;
      end
   end

   always_comb begin
      pq[0] = par_ff.rot_w;
      pq[1] = par_ff.rot_x;
      pq[2] = par_ff.rot_y;
      pq[3] = par_ff.rot_z;
      cq[0] = loc_ff.rot_w;
      cq[1] = loc_ff.rot_x;
      cq[2] = loc_ff.rot_y;
      cq[3] = loc_ff.rot_z;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_LOAD: begin
            for (int i = 0; i < 4; i++) begin
               for (int j = 0; j < 4; j++) begin
                  qp_ff[4*i+j] <= pq[i] * cq[j];
               end
            end
            sp_ff[0] <= par_ff.scale_x * loc_ff.scale_x;
            sp_ff[1] <= par_ff.scale_y * loc_ff.scale_y;
            sp_ff[2] <= par_ff.scale_z * loc_ff.scale_z;
            vp_ff[0] <= par_ff.scale_x * loc_ff.move_x;
            vp_ff[1] <= par_ff.scale_y * loc_ff.move_y;
            vp_ff[2] <= par_ff.scale_z * loc_ff.move_z;
         end
         ST_SUM: begin
            rot_ff[0] <= sat16(rnd(64'(qp_ff[0]) - 64'(qp_ff[5])
                                   - 64'(qp_ff[10]) - 64'(qp_ff[15]), 14));
            rot_ff[1] <= sat16(rnd(64'(qp_ff[1]) + 64'(qp_ff[4])
                                   + 64'(qp_ff[11]) - 64'(qp_ff[14]), 14));
            rot_ff[2] <= sat16(rnd(64'(qp_ff[2]) - 64'(qp_ff[7])
                                   + 64'(qp_ff[8]) + 64'(qp_ff[13]), 14));
            rot_ff[3] <= sat16(rnd(64'(qp_ff[3]) + 64'(qp_ff[6])
                                   - 64'(qp_ff[9]) + 64'(qp_ff[12]), 14));
            for (int i = 0; i < 3; i++) begin
               scl_ff[i] <= sat24(rnd(64'(sp_ff[i]), 16));
               v_ff[i]   <= rnd(64'(vp_ff[i]), 16);
            end
         end
         ST_UVP: begin
            uvp_ff[0] <= pq[2] * v_ff[2];
            uvp_ff[1] <= pq[3] * v_ff[1];
            uvp_ff[2] <= pq[3] * v_ff[0];
            uvp_ff[3] <= pq[1] * v_ff[2];
            uvp_ff[4] <= pq[1] * v_ff[1];
            uvp_ff[5] <= pq[2] * v_ff[0];
         end
         ST_UVR: begin
            for (int i = 0; i < 3; i++) begin
               uv_ff[i] <= rnd(uvp_ff[2*i] - uvp_ff[2*i+1], 14);
            end
         end
         ST_UUP: begin
            uup_ff[0] <= pq[2] * uv_ff[2];
            uup_ff[1] <= pq[3] * uv_ff[1];
            uup_ff[2] <= pq[3] * uv_ff[0];
            uup_ff[3] <= pq[1] * uv_ff[2];
            uup_ff[4] <= pq[1] * uv_ff[1];
            uup_ff[5] <= pq[2] * uv_ff[0];
            for (int i = 0; i < 3; i++) begin
               uvw_ff[i] <= uv_ff[i] * pq[0];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mv[0] = 64'(par_ff.move_x);
      mv[1] = 64'(par_ff.move_y);
      mv[2] = 64'(par_ff.move_z);
      if (ok_ff) begin
         world.rot_w   = rot_ff[0];
         world.rot_x   = rot_ff[1];
         world.rot_y   = rot_ff[2];
         world.rot_z   = rot_ff[3];
         world.scale_x = scl_ff[0];
         world.scale_y = scl_ff[1];
         world.scale_z = scl_ff[2];
         world.move_x  = sat32(mv[0] + v_ff[0] + 64'sd2 * (rnd(uvw_ff[0], 14)
                               + rnd(uup_ff[0] - uup_ff[1], 14)));
         world.move_y  = sat32(mv[1] + v_ff[1] + 64'sd2 * (rnd(uvw_ff[1], 14)
                               + rnd(uup_ff[2] - uup_ff[3], 14)));
         world.move_z  = sat32(mv[2] + v_ff[2] + 64'sd2 * (rnd(uvw_ff[2], 14)
                               + rnd(uup_ff[4] - uup_ff[5], 14)));
      end else begin
         world = loc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         bone_ff   <= full_ff ? 8'hFF : 8'(idx_ff);
         st_out_ff <= status_ff;
         out_ff    <= world;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bone_number   = bone_ff;
   assign rsp_status        = st_out_ff;
   assign rsp_world_rot_w   = out_ff.rot_w;
   assign rsp_world_rot_x   = out_ff.rot_x;
   assign rsp_world_rot_y   = out_ff.rot_y;
   assign rsp_world_rot_z   = out_ff.rot_z;
   assign rsp_world_scale_x = out_ff.scale_x;
   assign rsp_world_scale_y = out_ff.scale_y;
   assign rsp_world_scale_z = out_ff.scale_z;
   assign rsp_world_move_x  = out_ff.move_x;
   assign rsp_world_move_y  = out_ff.move_y;
   assign rsp_world_move_z  = out_ff.move_z;

endmodule
